### rtl/tlqs_pkg.sv
package tlqs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_WIDTH    = 8;
  localparam int LEVELS      = 3;

  localparam int TASK_ID_W   = 8;
  localparam int LEVEL_W     = 2;
  localparam int QUANTUM_W   = 16;
  localparam int STATUS_W    = 2;

  localparam int STORE_W     = (ID_WIDTH < TASK_ID_W) ? ID_WIDTH : TASK_ID_W;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W      = $clog2(LEVELS * QUEUE_DEPTH);

  localparam int OUT_FIFO_DEPTH = 3;
  localparam int OUT_PTR_W      = $clog2(OUT_FIFO_DEPTH);
  localparam int OUT_CNT_W      = $clog2(OUT_FIFO_DEPTH + 1);

  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd10;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_SELECT  = 1'b1;

  localparam logic [LEVEL_W-1:0] LVL_HIGH   = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_MEDIUM = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_LOW    = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_NONE   = 2'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_DROP  = 2'd2
  } status_t;

  typedef struct packed {
    logic                 grant_valid;
    logic [TASK_ID_W-1:0] granted_id;
    logic [LEVEL_W-1:0]   granted_level;
    logic [QUANTUM_W-1:0] granted_quantum;
    status_t              status;
  } result_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] pos);
    logic [PTR_W-1:0] nxt;
    if (pos == PTR_W'(QUEUE_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = pos + PTR_W'(1);
    end
    return nxt;
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [LEVEL_W-1:0] lvl,
                                                   input logic [PTR_W-1:0] pos);
    return ADDR_W'(lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(pos);
  endfunction

endpackage

### rtl/tlqs_queue_ctrl.sv
module tlqs_queue_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic                            op,
  input  logic [tlqs_pkg::TASK_ID_W-1:0]  task_id,
  input  logic [tlqs_pkg::LEVEL_W-1:0]    task_level,
  input  logic [tlqs_pkg::QUANTUM_W-1:0]  quantum,
  output logic                            res_valid,
  output tlqs_pkg::result_t               res
);
  import tlqs_pkg::*;

  logic [PTR_W-1:0] head [LEVELS];
  logic [PTR_W-1:0] tail [LEVELS];
  logic [OCC_W-1:0] occupancy [LEVELS];

  logic [STORE_W-1:0] store [LEVELS * QUEUE_DEPTH];
  logic [STORE_W-1:0] rd_id;

  logic                 grant;
  logic [LEVEL_W-1:0]   sel_level;
  logic                 enq_ok;
  status_t              status_next;
  logic                 wr_en;
  logic                 rd_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [ADDR_W-1:0]    rd_addr;

  logic                 r_grant;
  logic [LEVEL_W-1:0]   r_level;
  logic [QUANTUM_W-1:0] r_quantum;
  status_t              r_status;

  // strict priority over the non-empty levels
  always_comb begin
    grant     = 1'b1;
    sel_level = LVL_HIGH;
    if (occupancy[0] != '0) begin
      sel_level = LVL_HIGH;
    end else if (occupancy[1] != '0) begin
      sel_level = LVL_MEDIUM;
    end else if (occupancy[2] != '0) begin
      sel_level = LVL_LOW;
    end else begin
      grant = 1'b0;
    end
  end

  always_comb begin
    enq_ok      = 1'b0;
    status_next = ST_OK;
    wr_addr     = '0;
    rd_addr     = store_addr(sel_level, head[sel_level]);
    if (op == OP_ENQUEUE) begin
      if (task_level != LVL_NONE) begin
        if (occupancy[task_level] == OCC_W'(QUEUE_DEPTH)) begin
          status_next = ST_DROP;
        end else begin
          enq_ok  = 1'b1;
          wr_addr = store_addr(task_level, tail[task_level]);
        end
      end
    end else if (!grant) begin
      status_next = ST_EMPTY;
    end
  end

  assign wr_en = accept && (op == OP_ENQUEUE) && enq_ok;
  assign rd_en = accept && (op == OP_SELECT) && grant;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= task_id[STORE_W-1:0];
    end
    if (rd_en) begin
      rd_id <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        head[i]      <= '0;
        tail[i]      <= '0;
        occupancy[i] <= '0;
      end
    end else begin
      if (wr_en) begin
        tail[task_level]      <= ring_next(tail[task_level]);
        occupancy[task_level] <= occupancy[task_level] + OCC_W'(1);
      end
      if (rd_en) begin
        head[sel_level]      <= ring_next(head[sel_level]);
        occupancy[sel_level] <= occupancy[sel_level] - OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_grant   <= (op == OP_SELECT) && grant;
      r_level   <= ((op == OP_SELECT) && grant) ? sel_level : LVL_HIGH;
      r_quantum <= ((op == OP_SELECT) && grant && sel_level == LVL_HIGH) ? quantum : '0;
      r_status  <= status_next;
    end
  end

  always_comb begin
    res.grant_valid     = r_grant;
    res.granted_id      = r_grant ? TASK_ID_W'(rd_id) : '0;
    res.granted_level   = r_level;
    res.granted_quantum = r_quantum;
    res.status          = r_status;
  end

endmodule

### rtl/tlqs_out_fifo.sv
module tlqs_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tlqs_pkg::result_t push_data,
  input  logic              pop,
  output logic              not_empty,
  output logic              full_ahead,
  output tlqs_pkg::result_t head_data
);
  import tlqs_pkg::*;

  result_t              entry [OUT_FIFO_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic [OUT_CNT_W-1:0] count;

  function automatic logic [OUT_PTR_W-1:0] fifo_next(input logic [OUT_PTR_W-1:0] p);
    return (p == OUT_PTR_W'(OUT_FIFO_DEPTH - 1)) ? '0 : p + OUT_PTR_W'(1);
  endfunction

  assign not_empty = (count != '0);
  assign head_data = entry[rd_ptr];

  // one word may still be in flight from the queue stage
  assign full_ahead = ({1'b0, count} + {{OUT_CNT_W{1'b0}}, push})
                      >= (OUT_CNT_W + 1)'(OUT_FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= fifo_next(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= fifo_next(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + OUT_CNT_W'(1);
      end else if (!push && pop) begin
        count <= count - OUT_CNT_W'(1);
      end
    end
  end

endmodule

### rtl/three_level_queue_scheduler.sv
// Path: an accepted word's result is registered in the queue stage, then
// written into the output FIFO, whose count raises out_valid.
// Throughput: one word per cycle while in_stall is low, enqueue or select
// alike; the queue pointers and the task store take one access per item.
// Reset: all three queues empty, round_robin_quantum back to 10; the
// task store itself is not cleared.
module three_level_queue_scheduler (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            op,
  input  logic [tlqs_pkg::TASK_ID_W-1:0]  task_id,
  input  logic [tlqs_pkg::LEVEL_W-1:0]    task_level,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            grant_valid,
  output logic [tlqs_pkg::TASK_ID_W-1:0]  granted_id,
  output logic [tlqs_pkg::LEVEL_W-1:0]    granted_level,
  output logic [tlqs_pkg::QUANTUM_W-1:0]  granted_quantum,
  output logic [tlqs_pkg::STATUS_W-1:0]   status,
  input  logic                            cfg_write_en,
  input  logic [tlqs_pkg::QUANTUM_W-1:0]  cfg_write_data
);
  import tlqs_pkg::*;

  logic [QUANTUM_W-1:0] round_robin_quantum;
  logic                 accept;
  logic                 res_valid;
  result_t              res;
  logic                 pop;
  logic                 full_ahead;
  result_t              head_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      round_robin_quantum <= QUANTUM_RESET;
    end else if (cfg_write_en) begin
      round_robin_quantum <= cfg_write_data;
    end
  end

  assign in_stall = full_ahead;
  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  tlqs_queue_ctrl u_queue_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .op         (op),
    .task_id    (task_id),
    .task_level (task_level),
    .quantum    (round_robin_quantum),
    .res_valid  (res_valid),
    .res        (res)
  );

  tlqs_out_fifo u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_data  (res),
    .pop        (pop),
    .not_empty  (out_valid),
    .full_ahead (full_ahead),
    .head_data  (head_data)
  );

  assign grant_valid     = head_data.grant_valid;
  assign granted_id      = head_data.granted_id;
  assign granted_level   = head_data.granted_level;
  assign granted_quantum = head_data.granted_quantum;
  assign status          = head_data.status;

endmodule

### tb/sv/testbench.sv
module testbench;
  import tlqs_pkg::*;

  typedef struct {
    logic                 op;
    logic [TASK_ID_W-1:0] id;
    logic [LEVEL_W-1:0]   lvl;
    int                   reps;
    bit                   typed;
    result_t              want;
  } stim_row_t;

  logic                 clk;
  logic                 rst            = 1'b1;
  logic                 in_valid       = 1'b0;
  logic                 in_stall;
  logic                 op             = OP_ENQUEUE;
  logic [TASK_ID_W-1:0] task_id        = '0;
  logic [LEVEL_W-1:0]   task_level     = LVL_HIGH;
  logic                 out_valid;
  logic                 out_stall      = 1'b0;
  logic                 grant_valid;
  logic [TASK_ID_W-1:0] granted_id;
  logic [LEVEL_W-1:0]   granted_level;
  logic [QUANTUM_W-1:0] granted_quantum;
  logic [STATUS_W-1:0]  status;
  logic                 cfg_write_en   = 1'b0;
  logic [QUANTUM_W-1:0] cfg_write_data = '0;

  // scheduler state as seen from the outside
  logic [STORE_W-1:0]   ring_q [LEVELS][QUEUE_DEPTH];
  int                   head_q [LEVELS];
  int                   tail_q [LEVELS];
  int                   fill_q [LEVELS];
  logic [QUANTUM_W-1:0] quantum_q;

  result_t   expected_grants[$];
  result_t   oldest;
  stim_row_t directed [11];
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  int        mismatches     = 0;
  int        n_grants       = 0;
  int        n_drops        = 0;
  int        n_empty        = 0;
  int        n_words        = 0;

  three_level_queue_scheduler dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .op              (op),
    .task_id         (task_id),
    .task_level      (task_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .grant_valid     (grant_valid),
    .granted_id      (granted_id),
    .granted_level   (granted_level),
    .granted_quantum (granted_quantum),
    .status          (status),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[three_level_queue_scheduler] ERROR");
    $finish;
  end

  function automatic void clear_queues();
    for (int l = 0; l < LEVELS; l++) begin
      head_q[l] = 0;
      tail_q[l] = 0;
      fill_q[l] = 0;
    end
    quantum_q = QUANTUM_RESET;
  endfunction

  // Apply one accepted word to the queues and return the result it gives.
  function automatic result_t schedule_word(input logic op_w,
                                            input logic [TASK_ID_W-1:0] id_w,
                                            input logic [LEVEL_W-1:0] lvl_w);
    result_t r;
    int      lv;
    r = '0;
    r.status = ST_OK;
    if (op_w == OP_ENQUEUE) begin
      if (lvl_w < LEVELS) begin
        lv = lvl_w;
        if (fill_q[lv] == QUEUE_DEPTH) begin
          r.status = ST_DROP;
        end else begin
          ring_q[lv][tail_q[lv]] = id_w[STORE_W-1:0];
          tail_q[lv] = (tail_q[lv] + 1) % QUEUE_DEPTH;
          fill_q[lv]++;
        end
      end
    end else begin
      lv = 0;
      while (lv < LEVELS && fill_q[lv] == 0) lv++;
      if (lv == LEVELS) begin
        r.status = ST_EMPTY;
      end else begin
        r.grant_valid     = 1'b1;
        r.granted_id      = TASK_ID_W'(ring_q[lv][head_q[lv]]);
        r.granted_level   = LEVEL_W'(lv);
        r.granted_quantum = (lv == 0) ? quantum_q : '0;
        head_q[lv] = (head_q[lv] + 1) % QUEUE_DEPTH;
        fill_q[lv]--;
      end
    end
    return r;
  endfunction

  function automatic stim_row_t row(input logic op_w, input logic [TASK_ID_W-1:0] id_w,
                                    input logic [LEVEL_W-1:0] lvl_w, input int reps,
                                    input bit typed, input logic gv,
                                    input logic [TASK_ID_W-1:0] gid,
                                    input logic [LEVEL_W-1:0] glvl,
                                    input logic [QUANTUM_W-1:0] gq, input status_t st);
    stim_row_t s;
    s.op    = op_w;
    s.id    = id_w;
    s.lvl   = lvl_w;
    s.reps  = reps;
    s.typed = typed;
    s.want  = '{grant_valid: gv, granted_id: gid, granted_level: glvl,
                granted_quantum: gq, status: st};
    return s;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_word(input logic op_w, input logic [TASK_ID_W-1:0] id_w,
                           input logic [LEVEL_W-1:0] lvl_w, input bit typed,
                           input result_t want);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= op_w;
    task_id    <= id_w;
    task_level <= lvl_w;
    do @(posedge clk); while (in_stall);
    predicted = schedule_word(op_w, id_w, lvl_w);
    expected_grants.push_back(typed ? want : predicted);
    n_words++;
  endtask

  // Hold the sender until every pending word has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_quantum(input logic [QUANTUM_W-1:0] value);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    quantum_q = value;
  endtask

  task automatic run_random(input int count);
    int                   done;
    int                   enq_pct;
    logic                 op_w;
    logic [LEVEL_W-1:0]   lvl_w;
    logic [TASK_ID_W-1:0] id_w;
    done    = 0;
    enq_pct = 50;
    while (done < count) begin
      // bursts lean toward filling or toward draining the queues, or stay even
      if (done % 20 == 0) begin
        case ($urandom_range(2))
          0:       enq_pct = 15;
          1:       enq_pct = 50;
          default: enq_pct = 85;
        endcase
      end
      op_w  = ($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_SELECT;
      lvl_w = ($urandom_range(15) == 0) ? LVL_NONE : LEVEL_W'($urandom_range(2));
      id_w  = TASK_ID_W'($urandom_range(255));
      send_word(op_w, id_w, lvl_w, 1'b0, '0);
      if (!(op_w == OP_ENQUEUE && lvl_w == LVL_NONE)) begin
        done++;
      end
      if (done == count / 2) begin
        wait_drained();
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_grants.size() == 0) begin
        $error("result word with nothing pending");
        mismatches++;
      end else begin
        oldest = expected_grants.pop_front();
        check_field("grant_valid", oldest.grant_valid, grant_valid);
        check_field("granted_id", oldest.granted_id, granted_id);
        check_field("granted_level", oldest.granted_level, granted_level);
        check_field("granted_quantum", oldest.granted_quantum, granted_quantum);
        check_field("status", oldest.status, status);
      end
      if (grant_valid) n_grants++;
      if (status == ST_DROP) n_drops++;
      if (status == ST_EMPTY) n_empty++;
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    logic [QUANTUM_W-1:0] quantum_plan [4];

    clear_queues();
    directed[0]  = row(OP_SELECT,  8'hFF, LVL_NONE,   1, 1, 0, 8'h00, LVL_HIGH, 0, ST_EMPTY);
    directed[1]  = row(OP_ENQUEUE, 8'hFF, LVL_NONE,   1, 1, 0, 8'h00, LVL_HIGH, 0, ST_OK);
    // level three must not have created an entry
    directed[2]  = row(OP_SELECT,  8'h00, LVL_HIGH,   1, 1, 0, 8'h00, LVL_HIGH, 0, ST_EMPTY);
    directed[3]  = row(OP_ENQUEUE, 8'h00, LVL_HIGH,   1, 1, 0, 8'h00, LVL_HIGH, 0, ST_OK);
    directed[4]  = row(OP_ENQUEUE, 8'hFF, LVL_MEDIUM, 1, 1, 0, 8'h00, LVL_HIGH, 0, ST_OK);
    directed[5]  = row(OP_ENQUEUE, 8'hA5, LVL_LOW,    1, 1, 0, 8'h00, LVL_HIGH, 0, ST_OK);
    directed[6]  = row(OP_SELECT,  8'h00, LVL_HIGH,   1, 1, 1, 8'h00, LVL_HIGH,
                       QUANTUM_RESET, ST_OK);
    directed[7]  = row(OP_SELECT,  8'h00, LVL_HIGH,   1, 1, 1, 8'hFF, LVL_MEDIUM, 0, ST_OK);
    directed[8]  = row(OP_SELECT,  8'h00, LVL_HIGH,   1, 1, 1, 8'hA5, LVL_LOW, 0, ST_OK);
    // fill the low queue, then one more word is dropped
    directed[9]  = row(OP_ENQUEUE, 8'h10, LVL_LOW, QUEUE_DEPTH, 0, 0, 8'h00, LVL_HIGH, 0,
                       ST_OK);
    directed[10] = row(OP_ENQUEUE, 8'h3C, LVL_LOW,    1, 1, 0, 8'h00, LVL_HIGH, 0, ST_DROP);

    quantum_plan[0] = 16'hFFFF;
    quantum_plan[1] = 16'h0000;
    quantum_plan[2] = QUANTUM_W'($urandom_range(65535));
    quantum_plan[3] = 16'h0001;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < 11; i++) begin
      for (int r = 0; r < directed[i].reps; r++) begin
        send_word(directed[i].op, directed[i].id + TASK_ID_W'(r), directed[i].lvl,
                  directed[i].typed, directed[i].want);
      end
    end
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      write_quantum(quantum_plan[p]);
      run_random(185);
      wait_drained();
    end

    $display("Sent %0d words over four quanta and idle mixes: %0d grants, %0d drops,",
             n_words, n_grants, n_drops);
    $display("%0d selects on empty queues, %0d field mismatches.", n_empty, mismatches);
    if (mismatches == 0) begin
      $display("[three_level_queue_scheduler] OK");
    end else begin
      $display("[three_level_queue_scheduler] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/tlqs_pkg.sv
rtl/tlqs_queue_ctrl.sv
rtl/tlqs_out_fifo.sv
rtl/three_level_queue_scheduler.sv
tb/sv/testbench.sv
